// ===== rtl/core/running_sample_statistics_top_assert.svh =====
// Assertion macros shared by the checker of the statistics block.
`ifndef RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH
`define RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RSS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rss_pkg.sv =====
package rss_pkg;

   // field and accumulator widths
   localparam int SAMPLE_W    = 24;
   localparam int TALLY_W     = 17;
   localparam int SUM_W       = 40;
   localparam int SQ_W        = 63;
   localparam int SQR_W       = 2 * SAMPLE_W;
   localparam int PROD_W      = 80;
   localparam int DVSR_W      = 32;
   localparam int SPREAD_W    = 49;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_FIELD_W = TALLY_W + SUM_W + 3 * SAMPLE_W + SPREAD_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // iteration counts of the shift-add multiplier and restoring divider
   localparam int MUL_STEPS  = SUM_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // parameter defaults
   localparam int DEF_MAX_SAMPLES = 65536;
   localparam int DEF_SAMPLE_BITS = 24;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_SATURATED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_LOAD_A,
      ST_MUL_A,
      ST_LOAD_B,
      ST_MUL_B,
      ST_LOAD_V,
      ST_DIV_V,
      ST_LOAD_M,
      ST_DIV_M,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_stage;
      logic accum_en;
      logic mul_load_sq;
      logic mul_load_sum;
      logic mul_step;
      logic div_load_var;
      logic div_load_avg;
      logic div_step;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stage_valid;
      logic stage_last;
   } stat_type;

endpackage

// ===== rtl/core/running_sample_statistics_top.sv =====
// Running statistics over a stream of signed Q8.16 samples.
// Input channel (req_): tdata holds the sample, tuser flags it numeric (a
// non-numeric sample is skipped), tlast closes the data set.
// Result channel (rsp_): one transaction per data set, sent after the item
// with tlast; tuser carries the status (ok, empty, saturated), tdata the
// count, sum, mean, minimum, maximum and sample variance.
// Throughput: one sample per cycle while a data set runs.
// The result is set by the 40-step shift-add multiplier run twice (n*sumsq
// and sum^2) and the 80-step restoring divider run twice (variance, mean).
// req_tready is low from the tlast transaction until the result has been
// loaded into the output register; the next data set may start while that
// result still waits. If the receiver stalls with a result pending, a second
// finished data set holds in the final state until the register frees up.
// Once MAX_SAMPLES numeric samples are counted, further ones are dropped and
// the result reports the saturated status.
// Reset clears all accumulators and the pending result; no clearing pass.
module running_sample_statistics_top
   import rss_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [23:0] sample
   input  logic                  req_tuser,  // [0] is_numeric
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [16:0] sample_total, [56:17] running_sum, [80:57] average,
   // [104:81] smallest, [128:105] largest, [177:129] spread, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   cmd_type  cmd;
   stat_type stat;

   rss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rss_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== rtl/core/rss_datapath.sv =====
module rss_datapath
   import rss_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int EXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

   // input stage
   logic                       stage_valid_ff;
   logic                       stage_last_ff;
   logic                       stage_num_ff;
   logic signed [SAMPLE_W-1:0] stage_s_ff;
   logic [SQR_W-1:0]           stage_sq_ff;

   // accumulators
   logic [TALLY_W-1:0]         tally_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [SQ_W-1:0]            sumsq_ff;
   logic signed [SAMPLE_W-1:0] low_ff;
   logic signed [SAMPLE_W-1:0] high_ff;
   logic                       drop_ff;

   // multiplier and divider
   logic [PROD_W-1:0]   mcand_ff;
   logic [SUM_W-1:0]    mplier_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   numa_ff;
   logic [DVSR_W-1:0]   rem_ff;
   logic [PROD_W-1:0]   quo_ff;
   logic [DVSR_W-1:0]   dvsr_ff;
   logic [SPREAD_W-1:0] var_ff;

   // output register
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_stat_ff;

   logic signed [SAMPLE_W-1:0] shl_s;
   logic signed [SAMPLE_W-1:0] ext_s;
   logic [SAMPLE_W-1:0]        ext_mag;
   logic [SQR_W-1:0]           ext_sq;
   logic                       full;
   logic [SUM_W-1:0]           sum_mag;
   logic [PROD_W-1:0]          var_num;
   logic [2*TALLY_W-1:0]       pair_cnt;
   logic [DVSR_W:0]            div_trial;
   logic [DVSR_W:0]            div_diff;
   logic                       div_ge;
   logic [SUM_W-1:0]           avg_full;
   logic                       empty;
   logic [STATUS_W-1:0]        rsp_stat_in;
   logic [RSP_DATA_W-1:0]      rsp_data_in;
   logic [SPREAD_W-1:0]        spread_out;

   // sign extension from SAMPLE_BITS and square of the magnitude
   assign shl_s   = req_tdata[SAMPLE_W-1:0] << EXT_SHIFT;
   assign ext_s   = shl_s >>> EXT_SHIFT;
   assign ext_mag = ext_s[SAMPLE_W-1] ? (~ext_s + 1'b1) : ext_s;
   assign ext_sq  = ext_mag * ext_mag;

   assign stat.stage_valid = stage_valid_ff;
   assign stat.stage_last  = stage_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (cmd.load_stage) begin
         stage_valid_ff <= 1'b1;
      end else if (cmd.accum_en) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_stage) begin
         stage_last_ff <= req_tlast;
         stage_num_ff  <= req_tuser;
         stage_s_ff    <= ext_s;
         stage_sq_ff   <= ext_sq;
      end
   end

   // accumulation, one sample per cycle while the controller is in its accumulate state
   assign full = (tally_ff >= TALLY_W'(MAX_SAMPLES));

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         tally_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.accum_en && stage_valid_ff && stage_num_ff) begin
         if (full) begin
            drop_ff <= 1'b1;
         end else begin
            tally_ff <= tally_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_W'(stage_s_ff);
            sumsq_ff <= sumsq_ff + SQ_W'(stage_sq_ff);
            if (tally_ff == '0 || stage_s_ff < low_ff) begin
               low_ff <= stage_s_ff;
            end
            if (tally_ff == '0 || stage_s_ff > high_ff) begin
               high_ff <= stage_s_ff;
            end
         end
      end
   end

   // operands for the final pass
   assign sum_mag  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign var_num  = (numa_ff >= prod_ff) ? (numa_ff - prod_ff) : '0;
   assign pair_cnt = tally_ff * (tally_ff - 1'b1);

   // shift-add multiplier: n*sumsq, then |sum|^2
   always_ff @(posedge clock) begin
      priority if (cmd.mul_load_sq) begin
         mcand_ff  <= PROD_W'(sumsq_ff);
         mplier_ff <= SUM_W'(tally_ff);
         prod_ff   <= '0;
      end else if (cmd.mul_load_sum) begin
         numa_ff   <= prod_ff;
         mcand_ff  <= PROD_W'(sum_mag);
         mplier_ff <= sum_mag;
         prod_ff   <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[SUM_W-1:1]};
      end else begin
         mcand_ff <= mcand_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign div_trial = {rem_ff, quo_ff[PROD_W-1]};
   assign div_ge    = (div_trial >= {1'b0, dvsr_ff});
   assign div_diff  = div_trial - {1'b0, dvsr_ff};

   always_ff @(posedge clock) begin
      priority if (cmd.div_load_var) begin
         quo_ff  <= var_num;
         rem_ff  <= '0;
         dvsr_ff <= pair_cnt[DVSR_W-1:0];
      end else if (cmd.div_load_avg) begin
         var_ff  <= quo_ff[SPREAD_W-1:0];
         quo_ff  <= PROD_W'(sum_mag);
         rem_ff  <= '0;
         dvsr_ff <= DVSR_W'(tally_ff);
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_diff[DVSR_W-1:0] : div_trial[DVSR_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], div_ge};
      end else begin
         rem_ff <= rem_ff;
      end
   end

   // result assembly
   assign empty      = (tally_ff == '0);
   assign avg_full   = sum_ff[SUM_W-1] ? (~quo_ff[SUM_W-1:0] + 1'b1) : quo_ff[SUM_W-1:0];
   assign spread_out = (tally_ff <= TALLY_W'(1)) ? '0 : var_ff;

   always_comb begin
      rsp_data_in = '0;
      priority if (empty) begin
         rsp_stat_in = STAT_EMPTY;
      end else begin
         rsp_stat_in = drop_ff ? STAT_SATURATED : STAT_OK;
         rsp_data_in = RSP_DATA_W'({spread_out, high_ff, low_ff,
                                    avg_full[SAMPLE_W-1:0], sum_ff, tally_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_stat_ff <= rsp_stat_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_stat_ff;

endmodule

// ===== rtl/core/rss_ctrl.sv =====
module rss_ctrl
   import rss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type             state_ff;
   state_type             state_in;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [STEP_CNT_W-1:0] cnt_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  out_free;
   logic                  mul_end;
   logic                  div_end;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign mul_end  = (cnt_ff == STEP_CNT_W'(MUL_STEPS - 1));
   assign div_end  = (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (stat.stage_valid && stat.stage_last) begin
               state_in = ST_LOAD_A;
            end
         end
         ST_LOAD_A: state_in = ST_MUL_A;
         ST_MUL_A: begin
            if (mul_end) begin
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: state_in = ST_MUL_B;
         ST_MUL_B: begin
            if (mul_end) begin
               state_in = ST_LOAD_V;
            end
         end
         ST_LOAD_V: state_in = ST_DIV_V;
         ST_DIV_V: begin
            if (div_end) begin
               state_in = ST_LOAD_M;
            end
         end
         ST_LOAD_M: state_in = ST_DIV_M;
         ST_DIV_M: begin
            if (div_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // step counter for multiply and divide iterations
   always_comb begin
      unique case (state_ff)
         ST_MUL_A, ST_MUL_B, ST_DIV_V, ST_DIV_M: cnt_in = cnt_ff + 1'b1;
         default:                                cnt_in = '0;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready   = !(stat.stage_valid && stat.stage_last);
            cmd.accum_en = 1'b1;
         end
         ST_LOAD_A: cmd.mul_load_sq  = 1'b1;
         ST_LOAD_B: cmd.mul_load_sum = 1'b1;
         ST_MUL_A, ST_MUL_B: cmd.mul_step = 1'b1;
         ST_LOAD_V: cmd.div_load_var = 1'b1;
         ST_LOAD_M: cmd.div_load_avg = 1'b1;
         ST_DIV_V, ST_DIV_M: cmd.div_step = 1'b1;
         ST_DONE: cmd.emit = out_free;
         default: cmd = '0;
      endcase
      cmd.load_stage = req_tvalid && req_tready;
   end

   // result valid flag
   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/rss_checker.sv =====
`include "running_sample_statistics_top_assert.svh"

module rss_checker
   import rss_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // a stalled result stays put
   `RSS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // input closes behind a tlast transaction while the result is computed
   `RSS_ASSERT_NEXT(a_last_closes, req_tvalid && req_tready && req_tlast, !req_tready, "input open right after tlast")

   // empty status exactly when the count is zero
   `RSS_ASSERT_SAME(a_empty_count, rsp_tvalid, (rsp_tuser == STAT_EMPTY) == (rsp_tdata[TALLY_W-1:0] == '0), "empty status and count disagree")

   // status code is one of the defined ones
   `RSS_ASSERT_SAME(a_status_code, rsp_tvalid, rsp_tuser == STAT_OK || rsp_tuser == STAT_EMPTY || rsp_tuser == STAT_SATURATED, "undefined status code")

   // minimum never exceeds maximum
   `RSS_ASSERT_SAME(a_min_max, rsp_tvalid && rsp_tuser != STAT_EMPTY, $signed(rsp_tdata[104:81]) <= $signed(rsp_tdata[128:105]), "minimum above maximum")

endmodule

bind running_sample_statistics_top rss_checker u_rss_checker (.*);
